### hdl/merged_palette_indexer_defines.svh
// Assertion macros for the merged palette indexer execution engine (mpi_back)
`ifndef MERGED_PALETTE_INDEXER_DEFINES_SVH
`define MERGED_PALETTE_INDEXER_DEFINES_SVH

// same-cycle implication
`define MPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mpi_pkg.sv
// Types and constants of the merged palette indexer
package mpi_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int unsigned SRC_DEPTH    = 256;
  localparam int unsigned MIN_REPORTED = 16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] source_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_image;
  } mpi_in_t;

  typedef struct packed {
    logic [7:0] merged_index;
    logic       new_color;
    logic       overflow;
    logic [8:0] color_count;
    logic [8:0] reported_count;
    logic       image_done;
  } mpi_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC,
    ST_FETCH,
    ST_CMP,
    ST_EMIT
  } mpi_state_e;

endpackage

### hdl/merged_palette_indexer.sv
// Top level: input queue, execution engine and result queue
// Usage:
//   Input side is a queue: drive in_item_i and push; an item is taken on a
//   clock edge with push high and full low. Opcodes: load a source palette
//   entry, map a pixel, clear the merged palette.
//   Result side is a queue: while empty is low, out_item_o holds the oldest
//   result; pop high on such an edge takes it. Every item yields one result.
// Sequencing:
//   Load, clear: the item is taken in IDLE and its result is pushed from EMIT.
//   Pixel: IDLE, SRC, then FETCH and CMP for each merged entry compared, and
//   EMIT on a match, an append or an overflow; the merged palette memory is
//   read one entry at a time (fetch, then compare) by one engine.
//   Items execute one at a time; two-entry queues on each side decouple.
// Reset:
//   Clears queues, state and the color count; palette memories keep contents.
// Stall:
//   When the result queue fills, the engine holds its result, then the input
//   queue fills and full rises.
module merged_palette_indexer import mpi_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = 256,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  mpi_in_t  in_item_i,
  output logic     full,
  input  logic     pop,
  output mpi_out_t out_item_o,
  output logic     empty
);

  mpi_in_t  head;
  logic     head_empty, head_pop;
  mpi_out_t res;
  logic     res_push, res_full;

  mpi_fifo #(.WIDTH($bits(mpi_in_t))) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item_i),
    .full_o  (full),
    .pop_i   (head_pop),
    .data_o  (head),
    .empty_o (head_empty)
  );

  mpi_back #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head),
    .item_empty_i (head_empty),
    .item_pop_o   (head_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  mpi_fifo #(.WIDTH($bits(mpi_out_t))) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

### hdl/mpi_fifo.sv
// Two-entry item queue with push/full and pop/empty sides
module mpi_fifo import mpi_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hdl/mpi_back.sv
// Execution engine: source palette, merged palette search and append
module mpi_back import mpi_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = 256,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mpi_in_t  item_i,
  input  logic     item_empty_i,
  output logic     item_pop_o,
  output mpi_out_t res_o,
  output logic     res_push_o,
  input  logic     res_full_i
);

  `include "merged_palette_indexer_defines.svh"

  localparam int unsigned SCB  = (CHANNEL_BITS < 8) ? CHANNEL_BITS : 8;
  localparam int unsigned CW   = 3 * SCB;
  localparam int unsigned IW   = $clog2(PALETTE_SIZE);
  localparam int unsigned CNTW = $clog2(PALETTE_SIZE + 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(PALETTE_SIZE);

  logic [CW-1:0]   src_mem [SRC_DEPTH];
  logic [CW-1:0]   mrg_mem [PALETTE_SIZE];
  logic [CW-1:0]   src_rd_q, mrd_q, col_q;
  logic [CW-1:0]   load_col;
  mpi_state_e      state_q, state_d;
  logic [CNTW-1:0] count_q, count_d, j_q, j_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            new_q, new_d, ovf_q, ovf_d, done_q, done_d;
  logic            src_we, mrg_we;

  assign load_col = {item_i.red[SCB-1:0], item_i.green[SCB-1:0], item_i.blue[SCB-1:0]};

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[item_i.source_index] <= load_col;
    end
    src_rd_q <= src_mem[item_i.source_index];
  end

  always_ff @(posedge clk_i) begin
    if (mrg_we) begin
      mrg_mem[count_q[IW-1:0]] <= col_q;
    end
    mrd_q <= mrg_mem[j_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    idx_q  <= idx_d;
    new_q  <= new_d;
    ovf_q  <= ovf_d;
    done_q <= done_d;
    if (state_q == ST_SRC) col_q <= src_rd_q;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    j_d        = j_q;
    idx_d      = idx_q;
    new_d      = new_q;
    ovf_d      = ovf_q;
    done_d     = done_q;
    src_we     = 1'b0;
    mrg_we     = 1'b0;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          idx_d  = '0;
          new_d  = 1'b0;
          ovf_d  = 1'b0;
          done_d = 1'b0;
          state_d = ST_EMIT;
          case (item_i.opcode)
            OP_LOAD:  src_we = 1'b1;
            OP_CLEAR: count_d = '0;
            OP_PIXEL: begin
              done_d  = item_i.end_of_image;
              state_d = ST_SRC;
            end
            default: ;
          endcase
        end
      end
      ST_SRC: begin
        j_d = '0;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (j_q == count_q) begin
          state_d = ST_EMIT;
          if (count_q != FULL_CNT) begin
            mrg_we  = 1'b1;
            idx_d   = count_q[IW-1:0];
            new_d   = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (mrd_q == col_q) begin
          idx_d   = j_q[IW-1:0];
          state_d = ST_EMIT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.merged_index   = 8'(idx_q);
    res_o.new_color      = new_q;
    res_o.overflow       = ovf_q;
    res_o.image_done     = done_q;
    res_o.color_count    = 9'(count_q);
    res_o.reported_count = (9'(count_q) < 9'(MIN_REPORTED)) ? 9'(MIN_REPORTED) : 9'(count_q);
  end

  `MPI_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_CNT, "count beyond palette size")
  `MPI_ASSERT_NOW(a_new_no_ovf, res_push_o, !(new_q && ovf_q), "new color and overflow together")
  `MPI_ASSERT_NEXT(a_grow_by_append, (state_q == ST_FETCH) && mrg_we,
                   count_q == $past(count_q) + 1'b1, "append did not advance count")
  `MPI_ASSERT_NOW(a_pop_idle, item_pop_o, state_q == ST_IDLE, "item taken while busy")

endmodule

### sim/merged_palette_indexer_tb.sv
// Self-checking testbench for the merged palette indexer: random and directed items, scoreboard
module merged_palette_indexer_tb;
  import mpi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  mpi_in_t  in_item_i = '0;
  logic     full;
  logic     pop = 1'b0;
  mpi_out_t out_item_o;
  logic     empty;

  merged_palette_indexer u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .full      (full),
    .pop       (pop),
    .out_item_o(out_item_o),
    .empty     (empty)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mpi_in_t     item_backlog[$];
  mpi_out_t    expected_results[$];
  logic [23:0] src_colors[256];
  logic [23:0] merged_colors[256];
  int unsigned merged_count = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          error_count = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;
  int          gen_items = 0;

  function automatic mpi_out_t map_item(mpi_in_t it);
    mpi_out_t    r;
    logic [23:0] c;
    bit          hit;
    r = '0;
    hit = 1'b0;
    if (it.opcode == OP_LOAD) begin
      src_colors[it.source_index] = {it.red, it.green, it.blue};
    end else if (it.opcode == OP_CLEAR) begin
      merged_count = 0;
    end else if (it.opcode == OP_PIXEL) begin
      c = src_colors[it.source_index];
      for (int j = 0; j < merged_count; j++) begin
        if (!hit && merged_colors[j] == c) begin
          hit = 1'b1;
          r.merged_index = j[7:0];
        end
      end
      if (!hit) begin
        if (merged_count < 256) begin
          merged_colors[merged_count] = c;
          r.merged_index = merged_count[7:0];
          merged_count++;
          r.new_color = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
      r.image_done = it.end_of_image;
    end
    r.color_count = merged_count[8:0];
    r.reported_count = (merged_count < MIN_REPORTED) ? 9'(MIN_REPORTED) : merged_count[8:0];
    return r;
  endfunction

  task automatic add_item(logic [1:0] op, logic [7:0] idx, logic [23:0] c, logic eoi);
    mpi_in_t it;
    it.opcode = op;
    it.source_index = idx;
    {it.red, it.green, it.blue} = c;
    it.end_of_image = eoi;
    item_backlog.push_back(it);
    gen_items++;
  endtask

  task automatic gen_image(int npix);
    int          nload;
    logic [7:0]  loaded[$];
    logic [7:0]  idx;
    logic [23:0] c;
    nload = $urandom_range(1, 8);
    for (int k = 0; k < nload; k++) begin
      idx = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) c = 24'(24'h3f3f3f * $urandom_range(0, 4));
      else c = 24'($urandom);
      add_item(OP_LOAD, idx, c, 1'($urandom_range(0, 1)));
      loaded.push_back(idx);
    end
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_item(OP_UNUSED, 8'($urandom), 24'($urandom), 1'($urandom));
      end
      idx = loaded[$urandom_range(0, loaded.size() - 1)];
      add_item(OP_PIXEL, idx, 24'($urandom), (k == npix - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  task automatic drain();
    while (item_backlog.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic fill_palette();
    add_item(OP_CLEAR, 8'($urandom), 24'($urandom), 1'b0);
    for (int i = 0; i < 256; i++) begin
      add_item(OP_LOAD, i[7:0], {i[7:0], ~i[7:0], 8'h5a}, 1'b0);
      add_item(OP_PIXEL, i[7:0], 24'h0, i == 255);
    end
    add_item(OP_LOAD, 8'd0, 24'h123456, 1'b0);
    add_item(OP_PIXEL, 8'd0, 24'h0, 1'b0);
    add_item(OP_PIXEL, 8'd255, 24'h0, 1'b1);
    add_item(OP_CLEAR, 8'($urandom), 24'($urandom), 1'b1);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_results.push_back(map_item(in_item_i));
        void'(item_backlog.pop_front());
      end
      if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        push <= 1'b1;
        in_item_i <= item_backlog[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen >= 150) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    mpi_out_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", out_item_o);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_item_o.merged_index !== e.merged_index) begin
            $error("merged_index exp %0d got %0d", e.merged_index, out_item_o.merged_index);
            error_count++;
          end
          if (out_item_o.new_color !== e.new_color) begin
            $error("new_color exp %0d got %0d", e.new_color, out_item_o.new_color);
            error_count++;
          end
          if (out_item_o.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, out_item_o.overflow);
            error_count++;
          end
          if (out_item_o.color_count !== e.color_count) begin
            $error("color_count exp %0d got %0d", e.color_count, out_item_o.color_count);
            error_count++;
          end
          if (out_item_o.reported_count !== e.reported_count) begin
            $error("reported_count exp %0d got %0d", e.reported_count,
                   out_item_o.reported_count);
            error_count++;
          end
          if (out_item_o.image_done !== e.image_done) begin
            $error("image_done exp %0d got %0d", e.image_done, out_item_o.image_done);
            error_count++;
          end
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int images;
    images = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_item(OP_LOAD, 8'd0, 24'h000000, 1'b0);
    add_item(OP_LOAD, 8'd255, 24'hffffff, 1'b1);
    add_item(OP_LOAD, 8'd128, 24'hffffff, 1'b0);
    add_item(OP_LOAD, 8'd1, 24'hff00aa, 1'b0);
    add_item(OP_PIXEL, 8'd0, 24'hffffff, 1'b0);
    add_item(OP_PIXEL, 8'd255, 24'h0, 1'b0);
    add_item(OP_PIXEL, 8'd128, 24'h0, 1'b0);
    add_item(OP_PIXEL, 8'd1, 24'h0, 1'b0);
    add_item(OP_PIXEL, 8'd0, 24'h0, 1'b1);
    add_item(OP_UNUSED, 8'hff, 24'hffffff, 1'b1);
    add_item(OP_UNUSED, 8'h00, 24'h000000, 1'b0);
    add_item(OP_LOAD, 8'd1, 24'h00ff55, 1'b0);
    add_item(OP_PIXEL, 8'd1, 24'h0, 1'b1);
    add_item(OP_CLEAR, 8'hff, 24'hffffff, 1'b1);
    add_item(OP_PIXEL, 8'd128, 24'h0, 1'b0);
    add_item(OP_PIXEL, 8'd0, 24'h0, 1'b1);
    add_item(OP_CLEAR, 8'h00, 24'h000000, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 52 : (ph == 3) ? 17 : 0;
      recv_idle = (ph == 2) ? 52 : (ph == 3) ? 17 : 0;
      if (ph == 1) fill_palette();
      while (gen_items < (ph + 1) * 240 + 550 * (ph >= 1)) begin
        gen_image($urandom_range(3, 30));
        images++;
        if (images % 4 == 0) begin
          add_item(OP_CLEAR, 8'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/mpi_pkg.sv
hdl/mpi_fifo.sv
hdl/mpi_back.sv
hdl/merged_palette_indexer.sv
sim/merged_palette_indexer_tb.sv
